/* rtl/rfd_pkg.sv */
`default_nettype none
package rfd_pkg;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;
  localparam logic [7:0] TYPE_MASK  = 8'h07;

  localparam int HEADER_BYTES = 19;

  localparam logic [15:0] OFF_LEN_LO   = 16'd1;
  localparam logic [15:0] OFF_LEN_HI   = 16'd2;
  localparam logic [15:0] OFF_CONTROL  = 16'd3;
  localparam logic [15:0] OFF_CMD_LO   = 16'd4;
  localparam logic [15:0] OFF_CMD_HI   = 16'd7;
  localparam logic [15:0] OFF_ADDR_LO  = 16'd8;
  localparam logic [15:0] OFF_ADDR_HI  = 16'd13;
  localparam logic [15:0] OFF_START2   = 16'(HEADER_BYTES - 1);

  localparam logic [15:0] MAX_LEN_RESET = 16'd10240;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_START2 = 3'd1;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd2;
  localparam logic [2:0] ERR_BAD_END   = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_CHECK   = 5'b01000,
    PH_END     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  control;
    logic [31:0] command;
    logic [47:0] address;
    logic [15:0] length;
    logic [2:0]  code;
  } rec_t;

endpackage
`default_nettype wire

/* rtl/radio_frame_deframer.sv */
// A result is pushed into the result queue when its byte is accepted and moves on into the output register.
// Input: one byte per cycle while the result queue is not full; the parser updates its state once per accepted byte.
// A four-entry result queue and the output register absorb output stalls.
// Reset (rst, synchronous, active high): hunting, queue empty, no output, max length 10240.
`default_nettype none
module radio_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       result_kind,
  output logic [7:0]       payload_byte,
  output logic [2:0]       frame_type,
  output logic             status_flag,
  output logic             ack_flag,
  output logic [31:0]      command_word,
  output logic [47:0]      peer_address,
  output logic [15:0]      payload_length,
  output logic [2:0]       error_code
);

  rfd_pkg::rec_t push_rec;
  rfd_pkg::rec_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  rfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .queue_full  (full),
    .push        (push),
    .rec         (push_rec)
  );

  rfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  rfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .frame_type     (frame_type),
    .status_flag    (status_flag),
    .ack_flag       (ack_flag),
    .command_word   (command_word),
    .peer_address   (peer_address),
    .payload_length (payload_length),
    .error_code     (error_code)
  );

endmodule
`default_nettype wire

/* rtl/rfd_front.sv */
`default_nettype none
module rfd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [15:0]   cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          queue_full,
  output logic               push,
  output rfd_pkg::rec_t      rec
);

  rfd_pkg::phase_t phase, phase_next;
  logic [15:0] max_len;
  logic [15:0] counter, counter_next;
  logic [15:0] length, length_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  control, control_next;
  logic [31:0] command, command_next;
  logic [47:0] address, address_next;
  logic [15:0] len_new;
  logic        accept;
  logic        emit;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;
  assign len_new  = {rx_byte, length[7:0]};

  always_comb begin
    phase_next   = phase;
    counter_next = counter;
    length_next  = length;
    sum_next     = sum;
    control_next = control;
    command_next = command;
    address_next = address;
    emit         = 1'b0;
    rec          = '0;
    unique case (phase)
      rfd_pkg::PH_HEADER: begin
        sum_next     = sum + rx_byte;
        counter_next = counter + 16'd1;
        if (counter == rfd_pkg::OFF_LEN_LO) begin
          length_next[7:0] = rx_byte;
        end else if (counter == rfd_pkg::OFF_LEN_HI) begin
          length_next = len_new;
          if (len_new > max_len) begin
            emit       = 1'b1;
            rec.kind   = rfd_pkg::KIND_REJECTED;
            rec.code   = rfd_pkg::ERR_TOO_LONG;
            phase_next = rfd_pkg::PH_HUNT;
          end
        end else if (counter == rfd_pkg::OFF_CONTROL) begin
          control_next = rx_byte;
        end else if (counter >= rfd_pkg::OFF_CMD_LO && counter <= rfd_pkg::OFF_CMD_HI) begin
          command_next[{counter[1:0], 3'b000} +: 8] = rx_byte;
        end else if (counter >= rfd_pkg::OFF_ADDR_LO && counter <= rfd_pkg::OFF_ADDR_HI) begin
          address_next = {address[39:0], rx_byte};
        end else if (counter >= rfd_pkg::OFF_START2) begin
          if (rx_byte != rfd_pkg::START_BYTE) begin
            emit       = 1'b1;
            rec.kind   = rfd_pkg::KIND_REJECTED;
            rec.code   = rfd_pkg::ERR_NO_START2;
            phase_next = rfd_pkg::PH_HUNT;
          end else begin
            counter_next = '0;
            phase_next   = (length != 16'd0) ? rfd_pkg::PH_PAYLOAD : rfd_pkg::PH_CHECK;
          end
        end
      end
      rfd_pkg::PH_PAYLOAD: begin
        sum_next     = sum + rx_byte;
        counter_next = counter + 16'd1;
        if (counter_next >= length) begin
          phase_next = rfd_pkg::PH_CHECK;
        end
        emit     = 1'b1;
        rec.kind = rfd_pkg::KIND_PAYLOAD;
        rec.data = rx_byte;
      end
      rfd_pkg::PH_CHECK: begin
        sum_next   = sum ^ rx_byte;
        phase_next = rfd_pkg::PH_END;
      end
      rfd_pkg::PH_END: begin
        emit       = 1'b1;
        phase_next = rfd_pkg::PH_HUNT;
        if (rx_byte != rfd_pkg::END_BYTE) begin
          rec.kind = rfd_pkg::KIND_REJECTED;
          rec.code = rfd_pkg::ERR_BAD_END;
        end else if (sum != 8'd0) begin
          rec.kind = rfd_pkg::KIND_REJECTED;
          rec.code = rfd_pkg::ERR_CHECKSUM;
        end else begin
          rec.kind    = rfd_pkg::KIND_ACCEPTED;
          rec.control = control;
          rec.command = command;
          rec.address = address;
          rec.length  = length;
          rec.code    = rfd_pkg::ERR_NONE;
        end
      end
      default: begin
        phase_next = rfd_pkg::PH_HUNT;
        if (rx_byte == rfd_pkg::START_BYTE) begin
          phase_next   = rfd_pkg::PH_HEADER;
          counter_next = 16'd1;
          sum_next     = rfd_pkg::START_BYTE;
          length_next  = '0;
          control_next = '0;
          command_next = '0;
          address_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rfd_pkg::PH_HUNT;
      max_len <= rfd_pkg::MAX_LEN_RESET;
      counter <= '0;
      length  <= '0;
      sum     <= '0;
      control <= '0;
      command <= '0;
      address <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (accept) begin
        phase   <= phase_next;
        counter <= counter_next;
        length  <= length_next;
        sum     <= sum_next;
        control <= control_next;
        command <= command_next;
        address <= address_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rfd_queue.sv */
`default_nettype none
module rfd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rfd_pkg::rec_t push_rec,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output rfd_pkg::rec_t      head
);

  rfd_pkg::rec_t mem [rfd_pkg::QUEUE_DEPTH];
  logic [rfd_pkg::PTR_W-1:0] wr_ptr;
  logic [rfd_pkg::PTR_W-1:0] rd_ptr;
  logic [rfd_pkg::CNT_W-1:0] count;

  assign full  = (count == rfd_pkg::CNT_W'(rfd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rfd_back.sv */
`default_nettype none
module rfd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          queue_empty,
  input  wire rfd_pkg::rec_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         result_kind,
  output logic [7:0]         payload_byte,
  output logic [2:0]         frame_type,
  output logic               status_flag,
  output logic               ack_flag,
  output logic [31:0]        command_word,
  output logic [47:0]        peer_address,
  output logic [15:0]        payload_length,
  output logic [2:0]         error_code
);

  logic [7:0] ctl_type;

  assign pop      = !queue_empty && (!out_valid || out_ready);
  assign ctl_type = head.control & rfd_pkg::TYPE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_kind    <= head.kind;
      payload_byte   <= head.data;
      frame_type     <= ctl_type[2:0];
      status_flag    <= head.control[6];
      ack_flag       <= head.control[7];
      command_word   <= head.command;
      peer_address   <= head.address;
      payload_length <= head.length;
      error_code     <= head.code;
    end
  end

endmodule
`default_nettype wire

/* tb/frame_checker.sv */
module frame_checker
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  result_kind,
  input  logic [7:0]  payload_byte,
  input  logic [2:0]  frame_type,
  input  logic        status_flag,
  input  logic        ack_flag,
  input  logic [31:0] command_word,
  input  logic [47:0] peer_address,
  input  logic [15:0] payload_length,
  input  logic [2:0]  error_code,
  output int          fail_count,
  output int          outstanding,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [2:0]  ftype;
    logic        status;
    logic        ack;
    logic [31:0] command;
    logic [47:0] address;
    logic [15:0] length;
    logic [2:0]  code;
  } frame_result_t;

  phase_t        phase;
  logic [15:0]   offset;
  logic [15:0]   frame_len;
  logic [15:0]   len_limit;
  logic [7:0]    sum;
  logic [7:0]    ctrl;
  logic [31:0]   cmd;
  logic [47:0]   addr;
  frame_result_t pending_results[$];
  frame_result_t want;

  task automatic reject_frame(input logic [2:0] code);
    frame_result_t r;
    r = '0;
    r.kind = KIND_REJECTED;
    r.code = code;
    pending_results.push_back(r);
    phase = PH_HUNT;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    frame_result_t r;
    r = '0;
    case (phase)
      PH_HEADER: begin
        sum = sum + b;
        if (offset == OFF_LEN_LO) begin
          frame_len[7:0] = b;
        end else if (offset == OFF_LEN_HI) begin
          frame_len[15:8] = b;
          if (frame_len > len_limit) begin
            reject_frame(ERR_TOO_LONG);
            return;
          end
        end else if (offset == OFF_CONTROL) begin
          ctrl = b;
        end else if (offset >= OFF_CMD_LO && offset <= OFF_CMD_HI) begin
          cmd = cmd | (32'(b) << (8 * (offset - OFF_CMD_LO)));
        end else if (offset >= OFF_ADDR_LO && offset <= OFF_ADDR_HI) begin
          addr = {addr[39:0], b};
        end else if (offset >= OFF_START2) begin
          if (b != START_BYTE) begin
            reject_frame(ERR_NO_START2);
          end else begin
            offset = '0;
            phase = (frame_len != 0) ? PH_PAYLOAD : PH_CHECK;
          end
          return;
        end
        offset = offset + 16'd1;
      end
      PH_PAYLOAD: begin
        sum = sum + b;
        offset = offset + 16'd1;
        if (offset >= frame_len) phase = PH_CHECK;
        r.kind = KIND_PAYLOAD;
        r.data = b;
        pending_results.push_back(r);
      end
      PH_CHECK: begin
        // xor leaves zero when the checksum byte matches the running sum
        sum = sum ^ b;
        phase = PH_END;
      end
      PH_END: begin
        if (b != END_BYTE) begin
          reject_frame(ERR_BAD_END);
        end else if (sum != 0) begin
          reject_frame(ERR_CHECKSUM);
        end else begin
          r.kind = KIND_ACCEPTED;
          r.ftype = 3'(ctrl & TYPE_MASK);
          r.status = ctrl[6];
          r.ack = ctrl[7];
          r.command = cmd;
          r.address = addr;
          r.length = frame_len;
          r.code = ERR_NONE;
          pending_results.push_back(r);
          phase = PH_HUNT;
        end
      end
      default: begin
        phase = PH_HUNT;
        if (b == START_BYTE) begin
          phase = PH_HEADER;
          offset = 16'd1;
          sum = START_BYTE;
          frame_len = '0;
          ctrl = '0;
          cmd = '0;
          addr = '0;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [47:0] exp_val,
                             input logic [47:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_HUNT;
      offset = '0;
      frame_len = '0;
      len_limit = MAX_LEN_RESET;
      sum = '0;
      ctrl = '0;
      cmd = '0;
      addr = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual kind %0d",
                   $time, result_kind);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("payload_byte", want.data, payload_byte);
          check_field("frame_type", want.ftype, frame_type);
          check_field("status_flag", want.status, status_flag);
          check_field("ack_flag", want.ack, ack_flag);
          check_field("command_word", want.command, command_word);
          check_field("peer_address", want.address, peer_address);
          check_field("payload_length", want.length, payload_length);
          check_field("error_code", want.code, error_code);
          checked++;
        end
      end
      if (in_valid && in_ready) parse_byte(rx_byte);
      if (cfg_wr_en) len_limit = cfg_wr_data;
    end
    outstanding <= pending_results.size();
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rfd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_BYTES  = 50;

  typedef enum {
    FLAW_NONE,
    FLAW_NO_START2,
    FLAW_CHECKSUM,
    FLAW_BAD_END,
    FLAW_SUM_AND_END,
    FLAW_TOO_LONG
  } flaw_t;

  typedef enum {RX_READY, RX_MOSTLY, RX_SPARSE, RX_PATTERN} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_type;
  logic        status_flag;
  logic        ack_flag;
  logic [31:0] command_word;
  logic [47:0] peer_address;
  logic [15:0] payload_length;
  logic [2:0]  error_code;
  int          fail_count;
  int          outstanding;
  int          checked;

  int          bytes_sent;
  int          frames_sent;
  int          flawed_frames;
  int          burst_left;
  int          cycles;
  bit          gaps_on;
  bit          hold_req;
  bit          hold_done;
  logic [15:0] len_limit_now;

  radio_frame_deframer DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .frame_type     (frame_type),
    .status_flag    (status_flag),
    .ack_flag       (ack_flag),
    .command_word   (command_word),
    .peer_address   (peer_address),
    .payload_length (payload_length),
    .error_code     (error_code)
  );

  frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .frame_type     (frame_type),
    .status_flag    (status_flag),
    .ack_flag       (ack_flag),
    .command_word   (command_word),
    .peer_address   (peer_address),
    .payload_length (payload_length),
    .error_code     (error_code),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .checked        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output side: own stall pattern, plus one long hold-off on request
  initial begin
    stall_mode_t mode;
    int mode_left;
    int tick;
    int hold_count;
    mode = RX_READY;
    mode_left = 0;
    tick = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_READY:  out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ((tick % 5) < 2);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    rx_byte <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    int i;
    for (i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (b == START_BYTE) b = ~b;
      push_byte(b);
    end
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [7:0] ctrl,
                            input logic [31:0] cmd, input logic [47:0] addr,
                            input flaw_t flaw);
    logic [7:0] hdr [19];
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    hdr[0] = START_BYTE;
    hdr[1] = len[7:0];
    hdr[2] = len[15:8];
    hdr[3] = ctrl;
    for (i = 0; i < 4; i++) hdr[4 + i] = cmd[8 * i +: 8];
    for (i = 0; i < 6; i++) hdr[8 + i] = addr[47 - 8 * i -: 8];
    for (i = 14; i < 18; i++) hdr[i] = 8'($urandom);
    hdr[18] = START_BYTE;
    if (flaw == FLAW_NO_START2) begin
      while (hdr[18] == START_BYTE) hdr[18] = 8'($urandom);
    end
    frames_sent++;
    if (flaw != FLAW_NONE) flawed_frames++;
    // rejected early; the rest of the stream is line noise
    if (flaw == FLAW_TOO_LONG) begin
      for (i = 0; i < 3; i++) push_byte(hdr[i]);
      send_noise($urandom_range(4, 20));
      return;
    end
    sum = '0;
    for (i = 0; i < 19; i++) begin
      push_byte(hdr[i]);
      sum = sum + hdr[i];
    end
    if (flaw == FLAW_NO_START2) begin
      send_noise($urandom_range(4, 20));
      return;
    end
    for (i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      push_byte(b);
      sum = sum + b;
    end
    if (flaw == FLAW_CHECKSUM || flaw == FLAW_SUM_AND_END) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    push_byte(sum);
    b = END_BYTE;
    if (flaw == FLAW_BAD_END || flaw == FLAW_SUM_AND_END) begin
      while (b == END_BYTE) b = 8'($urandom);
    end
    push_byte(b);
  endtask

  task automatic random_frame();
    flaw_t flaw;
    int pick;
    int cap;
    logic [15:0] len;
    pick = $urandom_range(0, 9);
    if (pick <= 5) flaw = FLAW_NONE;
    else if (pick == 6) flaw = FLAW_NO_START2;
    else if (pick == 7) flaw = FLAW_CHECKSUM;
    else if (pick == 8) flaw = $urandom_range(0, 1) ? FLAW_BAD_END : FLAW_SUM_AND_END;
    else flaw = FLAW_TOO_LONG;
    if (flaw == FLAW_TOO_LONG && len_limit_now == 16'hFFFF) flaw = FLAW_NONE;
    cap = (len_limit_now < 40) ? int'(len_limit_now) : 40;
    if (flaw == FLAW_TOO_LONG) begin
      if ($urandom_range(0, 1)) len = len_limit_now + 16'd1;
      else len = 16'($urandom_range(int'(len_limit_now) + 1, 65535));
    end else begin
      pick = $urandom_range(0, 7);
      if (pick == 0) len = 16'(cap);
      else if (pick == 1) len = 16'($urandom_range(0, cap));
      else len = 16'($urandom_range(0, (cap < 12) ? cap : 12));
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
    send_frame(len, 8'($urandom), $urandom, {16'($urandom), 32'($urandom)}, flaw);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_limit_now = value;
  endtask

  initial begin
    int phase_idx;
    int phase_end;
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    len_limit_now = MAX_LEN_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;

    send_frame(16'd0, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, FLAW_NONE);
    send_frame(16'd3, 8'h00, 32'h0000_0000, 48'h0000_0000_0000, FLAW_NONE);
    send_frame(16'd1, 8'h41, 32'h1234_5678, 48'h0102_0304_0506, FLAW_NONE);
    send_frame(16'd10241, 8'h82, 32'h0, 48'h0, FLAW_TOO_LONG);
    send_frame(16'hFFFF, 8'h82, 32'h0, 48'h0, FLAW_TOO_LONG);
    // start bytes buried in a rejected header must not restart the hunt
    send_frame(16'd2, 8'h68, 32'h6868_6868, 48'h6868_6868_6868, FLAW_NO_START2);
    send_frame(16'd2, 8'hC5, 32'hA5A5_5A5A, 48'h8000_0000_0001, FLAW_CHECKSUM);
    send_frame(16'd1, 8'h07, 32'h0000_0001, 48'h0000_0000_0080, FLAW_BAD_END);
    send_frame(16'd1, 8'h80, 32'h8000_0000, 48'h0000_0001_0000, FLAW_SUM_AND_END);

    for (phase_idx = 0; phase_idx < 5; phase_idx++) begin
      if (phase_idx > 0) begin
        wait_drained();
        case (phase_idx)
          1: write_limit(16'd0);
          2: write_limit(16'hFFFF);
          3: write_limit(16'd16);
          default: write_limit(16'($urandom_range(1, 30)));
        endcase
      end
      if (phase_idx == 0) begin
        hold_req = 1'b1;
        gaps_on = 1'b0;
        send_frame(16'd40, 8'($urandom), $urandom, {16'($urandom), 32'($urandom)},
                   FLAW_NONE);
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) random_frame();
    end
    wait_drained();

    $display("sent %0d bytes in %0d frames (%0d malformed), compared %0d results",
             bytes_sent, frames_sent, flawed_frames, checked);
    $display("length limits 10240, 0, 65535, 16 and %0d; one %0d-cycle output hold-off",
             len_limit_now, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
